[hdl/sld_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list package
// Command and status codes and the control struct shared by the cell row.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int RANK_W   = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANK      = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

[hdl/sld_cell.sv]
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the request value and shifts toward
// either neighbor on an insert or a delete.
// ----------------------------------------------------------------------------
module sld_cell (
  input  logic                               clk,
  input  sld_pkg::cell_ctrl_t                ctrl,
  input  logic signed [sld_pkg::VALUE_W-1:0] key,
  input  logic                               valid,
  input  logic signed [sld_pkg::VALUE_W-1:0] left_value,
  input  logic                               left_lt,
  input  logic signed [sld_pkg::VALUE_W-1:0] right_value,
  output logic signed [sld_pkg::VALUE_W-1:0] value,
  output logic                               lt,
  output logic                               eq
);

  assign lt = valid && (value < key);
  assign eq = valid && (value == key);

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      value <= left_lt ? key : left_value;
    end else if (ctrl.del && !lt) begin
      value <= right_value;
    end
  end

endmodule

[hdl/sorted_list_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// Sorted list insert and delete unit
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// The result is registered and shows in the cycle after the request; one request
// per cycle is taken while the result register is free or being read.
// The comparison in every cell plus the match reduction sets the cycle.
// Reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sld_pkg::CMD_W-1:0]           command,
  input  logic signed [sld_pkg::VALUE_W-1:0]  value,
  input  logic [sld_pkg::RANK_W-1:0]          rank,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sld_pkg::STATUS_W-1:0]        status,
  output logic [sld_pkg::COUNT_W-1:0]         count,
  output logic signed [sld_pkg::VALUE_W-1:0]  read_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << sld_pkg::RANK_W)) ? CAPACITY
                                                           : (1 << sld_pkg::RANK_W);

  logic [CNT_W-1:0]                  stored_count;
  logic [CNT_W-1:0]                  stored_count_next;
  logic signed [sld_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]               cell_lt;
  logic [CAPACITY-1:0]               cell_eq;
  logic [CAPACITY-1:0]               cell_valid;
  sld_pkg::cell_ctrl_t               ctrl;
  logic                              accept;
  logic                              full;
  logic                              found;
  logic [sld_pkg::STATUS_W-1:0]      status_next;
  logic signed [sld_pkg::VALUE_W-1:0] read_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (stored_count == CNT_W'(CAPACITY));
  assign found    = |cell_eq;

  assign ctrl.ins = accept && (command == sld_pkg::CMD_INSERT) && !full;
  assign ctrl.del = accept && (command == sld_pkg::CMD_DELETE) && found;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign cell_valid[g] = CNT_W'(g) < stored_count;
      sld_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .key         (value),
        .valid       (cell_valid[g]),
        .left_value  ((g == 0) ? value : cell_value[(g == 0) ? 0 : g - 1]),
        .left_lt     ((g == 0) ? 1'b0 : cell_lt[(g == 0) ? 0 : g - 1]),
        .right_value ((g == CAPACITY - 1) ? cell_value[g]
                                          : cell_value[(g == CAPACITY - 1) ? g : g + 1]),
        .value       (cell_value[g]),
        .lt          (cell_lt[g]),
        .eq          (cell_eq[g])
      );
    end
  endgenerate

  always_comb begin
    status_next       = sld_pkg::ST_OK;
    read_next         = '0;
    stored_count_next = stored_count;
    case (command)
      sld_pkg::CMD_INSERT: begin
        if (full) begin
          status_next = sld_pkg::ST_FULL;
        end else begin
          stored_count_next = stored_count + 1'b1;
        end
      end
      sld_pkg::CMD_DELETE: begin
        if (found) begin
          stored_count_next = stored_count - 1'b1;
        end else begin
          status_next = sld_pkg::ST_NOT_FOUND;
        end
      end
      sld_pkg::CMD_READ: begin
        if (CNT_W'(rank) >= stored_count || (CNT_W < sld_pkg::RANK_W &&
            {1'b0, rank} >= (sld_pkg::RANK_W + 1)'(CAPACITY))) begin
          status_next = sld_pkg::ST_RANK;
        end else begin
          for (int i = 0; i < RD_N; i++) begin
            if (sld_pkg::RANK_W'(i) == rank) begin
              read_next = cell_value[i];
            end
          end
        end
      end
      default: begin
        status_next = sld_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_count <= stored_count_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      count      <= sld_pkg::COUNT_W'(stored_count_next);
      read_value <= read_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    accept && command == sld_pkg::CMD_INSERT && !full |=>
      stored_count == $past(stored_count) + 1'b1)
    else $error("insert did not grow the list");

  a_rank_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sld_pkg::ST_RANK |-> read_value == '0)
    else $error("rank error result carries a value");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list unit testbench
// Sends insert, delete, read and unused commands with random gaps and random
// result stalls, predicts every result from a shadow copy of the sorted list,
// and compares status, count and read value for each accepted result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAPACITY = 32;
  localparam logic [sld_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [sld_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [sld_pkg::VALUE_W-1:0] VAL_MIN = 32'sh80000000;
  localparam int RANDOM_REQUESTS = 1425;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PH_FILL = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIX = 2;

  typedef struct {
    logic [sld_pkg::CMD_W-1:0]           command;
    logic signed [sld_pkg::VALUE_W-1:0]  value;
    logic [sld_pkg::RANK_W-1:0]          rank;
  } request_t;

  typedef struct {
    logic [sld_pkg::STATUS_W-1:0]        status;
    logic [sld_pkg::COUNT_W-1:0]         count;
    logic signed [sld_pkg::VALUE_W-1:0]  read_value;
  } result_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [sld_pkg::CMD_W-1:0]           command;
  logic signed [sld_pkg::VALUE_W-1:0]  value;
  logic [sld_pkg::RANK_W-1:0]          rank;
  logic                                out_valid;
  logic                                out_ready;
  logic [sld_pkg::STATUS_W-1:0]        status;
  logic [sld_pkg::COUNT_W-1:0]         count;
  logic signed [sld_pkg::VALUE_W-1:0]  read_value;

  request_t                            request_queue[$];
  result_t                             pending_results[$];
  logic signed [sld_pkg::VALUE_W-1:0]  recent_inserts[$];
  logic signed [sld_pkg::VALUE_W-1:0]  sorted_vals[CAPACITY];
  int                                  sorted_len;
  request_t                            next_req;
  result_t                             want;
  logic                                req_taken;
  int                                  gap_left;
  int                                  stall_left;
  int                                  calm_in;
  int                                  calm_out;
  int                                  total_requests;
  int                                  accepted_requests;
  int                                  error_count;
  int                                  cycles;

  sorted_list_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .rank(rank),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .count(count),
    .read_value(read_value)
  );

  function automatic result_t apply_request(request_t req);
    result_t res;
    int pos;
    res.status = sld_pkg::ST_OK;
    res.read_value = '0;
    pos = 0;
    if (req.command == sld_pkg::CMD_INSERT) begin
      if (sorted_len >= CAPACITY) begin
        res.status = sld_pkg::ST_FULL;
      end else begin
        while (pos < sorted_len && sorted_vals[pos] < req.value) pos++;
        for (int i = sorted_len; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = req.value;
        sorted_len++;
      end
    end else if (req.command == sld_pkg::CMD_DELETE) begin
      while (pos < sorted_len && sorted_vals[pos] != req.value) pos++;
      if (pos >= sorted_len) begin
        res.status = sld_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = pos; i < sorted_len - 1; i++) sorted_vals[i] = sorted_vals[i+1];
        sorted_len--;
      end
    end else if (req.command == sld_pkg::CMD_READ) begin
      if (int'(req.rank) >= sorted_len) begin
        res.status = sld_pkg::ST_RANK;
      end else begin
        res.read_value = sorted_vals[req.rank];
      end
    end
    res.count = sld_pkg::COUNT_W'(sorted_len);
    return res;
  endfunction

  function automatic int draw_wait();
    int w;
    case ($urandom_range(0, 2))
      0: w = 0;
      1: w = $urandom_range(0, 3);
      default: w = $urandom_range(0, 12);
    endcase
    return w;
  endfunction

  function automatic logic signed [sld_pkg::VALUE_W-1:0] gen_value();
    logic signed [sld_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      1, 2: v = $signed(sld_pkg::VALUE_W'($urandom_range(0, 16))) - 32'sd8;
      3: begin
        if (recent_inserts.size() > 0) begin
          v = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
        end else begin
          v = $urandom;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_req(logic [sld_pkg::CMD_W-1:0] cmd,
                          logic signed [sld_pkg::VALUE_W-1:0] val,
                          logic [sld_pkg::RANK_W-1:0] rk);
    request_t req;
    req.command = cmd;
    req.value = val;
    req.rank = rk;
    request_queue.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_queue.size() > 0) begin
        next_req = request_queue.pop_front();
        command <= next_req.command;
        value <= next_req.value;
        rank <= next_req.rank;
        in_valid <= 1'b1;
        if (calm_in > 0) begin
          calm_in--;
          gap_left <= 0;
        end else begin
          if ($urandom_range(0, 99) == 0) calm_in = 40;
          gap_left <= draw_wait();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    req_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      pending_results.push_back(apply_request('{command, value, rank}));
      accepted_requests <= accepted_requests + 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d count %0d read_value %0d",
                 $time, status, count, read_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, count);
          error_count++;
        end
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                   read_value);
          error_count++;
        end
      end
      if (calm_out > 0) begin
        calm_out--;
        stall_left <= 0;
      end else begin
        if ($urandom_range(0, 99) == 0) calm_out = 40;
        stall_left <= draw_wait();
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_left;
    int roll;
    int ins_pct;
    int del_pct;
    int rd_pct;
    int idx;
    logic signed [sld_pkg::VALUE_W-1:0] v;

    in_valid = 1'b0;
    out_ready = 1'b0;
    command = sld_pkg::CMD_INSERT;
    value = '0;
    rank = '0;
    req_taken = 1'b0;
    gap_left = 0;
    stall_left = 0;
    calm_in = 0;
    calm_out = 0;
    sorted_len = 0;
    accepted_requests = 0;
    error_count = 0;
    cycles = 0;

    push_req(sld_pkg::CMD_READ, '0, 5'd0);
    push_req(sld_pkg::CMD_DELETE, 32'sd0, '0);
    push_req(CMD_UNUSED, '0, '0);
    push_req(sld_pkg::CMD_INSERT, VAL_MAX, 5'd31);
    push_req(sld_pkg::CMD_INSERT, VAL_MIN, '0);
    push_req(sld_pkg::CMD_INSERT, 32'sd0, '0);
    push_req(sld_pkg::CMD_INSERT, -32'sd1, '0);
    push_req(sld_pkg::CMD_INSERT, 32'sd1, '0);
    push_req(sld_pkg::CMD_INSERT, 32'sd0, '0);
    push_req(sld_pkg::CMD_INSERT, VAL_MAX, '0);
    push_req(sld_pkg::CMD_READ, VAL_MAX, 5'd0);
    push_req(sld_pkg::CMD_READ, '0, 5'd2);
    push_req(sld_pkg::CMD_READ, '0, 5'd6);
    push_req(sld_pkg::CMD_READ, '0, 5'd7);
    push_req(sld_pkg::CMD_READ, '1, 5'd31);
    push_req(sld_pkg::CMD_DELETE, 32'sd0, '1);
    push_req(sld_pkg::CMD_DELETE, 32'sd5, '0);
    push_req(sld_pkg::CMD_DELETE, VAL_MIN, '0);
    push_req(sld_pkg::CMD_DELETE, VAL_MAX, '0);
    push_req(sld_pkg::CMD_READ, '0, 5'd4);
    push_req(CMD_UNUSED, '1, '1);
    push_req(sld_pkg::CMD_READ, '0, 5'd0);

    phase = PH_FILL;
    phase_left = 80;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase = $urandom_range(PH_FILL, PH_MIX);
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      case (phase)
        PH_FILL: begin ins_pct = 70; del_pct = 10; rd_pct = 15; end
        PH_DRAIN: begin ins_pct = 15; del_pct = 65; rd_pct = 15; end
        default: begin ins_pct = 40; del_pct = 35; rd_pct = 20; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        v = gen_value();
        recent_inserts.push_back(v);
        if (recent_inserts.size() > 64) void'(recent_inserts.pop_front());
        push_req(sld_pkg::CMD_INSERT, v, sld_pkg::RANK_W'($urandom));
      end else if (roll < ins_pct + del_pct) begin
        if (recent_inserts.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, recent_inserts.size() - 1);
          v = recent_inserts[idx];
          recent_inserts.delete(idx);
        end else begin
          v = gen_value();
        end
        push_req(sld_pkg::CMD_DELETE, v, sld_pkg::RANK_W'($urandom));
      end else if (roll < ins_pct + del_pct + rd_pct) begin
        push_req(sld_pkg::CMD_READ, $urandom, sld_pkg::RANK_W'($urandom));
      end else begin
        push_req(CMD_UNUSED, $urandom, sld_pkg::RANK_W'($urandom));
      end
    end
    total_requests = request_queue.size();

    while (accepted_requests < total_requests) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
